/* hw/rtl/bdq_pkg.sv */
// bdq_pkg: shared types, constants and request codes for the bounded deque.
// Used by bdq_front, bdq_queue, bdq_back and bounded_deque_with_positional_ops.
`default_nettype none

package bdq_pkg;

  // List capacity (2 .. 31) and derived widths
  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int POS_W   = 5;
  localparam int ECNT_W  = 5;
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int DATA_W  = 32;

  // Depth of the op queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Request codes
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd1;
  localparam logic [2:0] REQ_PUSH_REAR  = 3'd2;
  localparam logic [2:0] REQ_POP_REAR   = 3'd3;
  localparam logic [2:0] REQ_INSERT_AT  = 3'd4;
  localparam logic [2:0] REQ_DELETE_AT  = 3'd5;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_NOP = 2'd0,
    OP_INS = 2'd1,
    OP_DEL = 2'd2
  } op_kind_t;

  typedef enum logic [1:0] {
    SEL_FRONT = 2'd0,
    SEL_REAR  = 2'd1,
    SEL_INDEX = 2'd2
  } pos_sel_t;

  typedef struct packed {
    logic [2:0]               req_type;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] removed_value;
    status_t                  status;
    logic [ECNT_W-1:0]        entry_count;
  } res_t;

  // Classified operation handed from front to back
  typedef struct packed {
    op_kind_t                 kind;
    pos_sel_t                 sel;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
  } op_t;

endpackage

`default_nettype wire

/* hw/rtl/bounded_deque_with_positional_ops.sv */
// bounded_deque_with_positional_ops: top level of the bounded deque.
// Depends on bdq_pkg, bdq_front, bdq_queue and bdq_back.
//
// Usage:
//   Request channel: drive req (req_type, value, position) and raise start.
//   A request is taken at a rising edge where start is high and busy is
//   low. busy rises only while the op queue is full.
//   Result channel: done pulses for one cycle with res (removed_value,
//   status, entry_count). There is no way to hold results off; the
//   receiver must take each one in the cycle it appears.
//   The front decodes each request into a two-entry op queue; the back
//   pops the op at its head, updates a chain of DEPTH entry cells in
//   parallel and registers the result into res, so a result passes the
//   queue slot and then the result register. The back pops one op per
//   cycle; the sustained rate is one request per cycle, set by the cell chain shift.
//   Results come out in request order, one per request.
//   Reset: rst (synchronous) empties the list and the op queue and clears
//   done. Entry cells hold no reset value; only entries below the count
//   are ever read.
`default_nettype none

module bounded_deque_with_positional_ops (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire bdq_pkg::req_t req,
  output logic               busy,
  output logic               done,
  output bdq_pkg::res_t      res
);

  logic         q_push;
  logic         q_full;
  logic         q_not_empty;
  bdq_pkg::op_t front_op;
  bdq_pkg::op_t back_op;

  // Accept and classify requests
  bdq_front u_front (
    .start  (start),
    .req    (req),
    .q_full (q_full),
    .busy   (busy),
    .push   (q_push),
    .op     (front_op)
  );

  // Hold classified ops until the back takes them
  bdq_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_op     (front_op),
    .pop       (q_not_empty),
    .full      (q_full),
    .not_empty (q_not_empty),
    .rd_op     (back_op)
  );

  // Drain one op per cycle into the cell chain
  bdq_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (q_not_empty),
    .op       (back_op),
    .done     (done),
    .res      (res)
  );

endmodule

`default_nettype wire

/* hw/rtl/bdq_front.sv */
// bdq_front: request acceptance and decode into a classified op.
// Depends on bdq_pkg.
`default_nettype none

module bdq_front (
  input  wire logic          start,
  input  wire bdq_pkg::req_t req,
  input  wire logic          q_full,
  output logic               busy,
  output logic               push,
  output bdq_pkg::op_t       op
);

  assign busy = q_full;
  assign push = start && !q_full;

  always_comb begin
    op.value    = req.value;
    op.position = req.position;
    op.kind     = bdq_pkg::OP_NOP;
    op.sel      = bdq_pkg::SEL_INDEX;
    unique case (req.req_type)
      bdq_pkg::REQ_PUSH_FRONT: begin
        op.kind = bdq_pkg::OP_INS;
        op.sel  = bdq_pkg::SEL_FRONT;
      end
      bdq_pkg::REQ_POP_FRONT: begin
        op.kind = bdq_pkg::OP_DEL;
        op.sel  = bdq_pkg::SEL_FRONT;
      end
      bdq_pkg::REQ_PUSH_REAR: begin
        op.kind = bdq_pkg::OP_INS;
        op.sel  = bdq_pkg::SEL_REAR;
      end
      bdq_pkg::REQ_POP_REAR: begin
        op.kind = bdq_pkg::OP_DEL;
        op.sel  = bdq_pkg::SEL_REAR;
      end
      bdq_pkg::REQ_INSERT_AT: begin
        op.kind = bdq_pkg::OP_INS;
      end
      bdq_pkg::REQ_DELETE_AT: begin
        op.kind = bdq_pkg::OP_DEL;
      end
      default: begin
        op.kind = bdq_pkg::OP_NOP;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/bdq_queue.sv */
// bdq_queue: short op queue that decouples front from back.
// Depends on bdq_pkg.
`default_nettype none

module bdq_queue (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire bdq_pkg::op_t wr_op,
  input  wire logic         pop,
  output logic              full,
  output logic              not_empty,
  output bdq_pkg::op_t      rd_op
);

  bdq_pkg::op_t                 slots [bdq_pkg::QDEPTH];
  logic [bdq_pkg::QPTR_W-1:0]   wr_ptr;
  logic [bdq_pkg::QPTR_W-1:0]   rd_ptr;
  logic [bdq_pkg::QCNT_W-1:0]   fill;

  assign full      = (fill == bdq_pkg::QCNT_W'(bdq_pkg::QDEPTH));
  assign not_empty = (fill != '0);
  assign rd_op     = slots[rd_ptr];

  // Advance a pointer with wrap at the queue depth
  function automatic logic [bdq_pkg::QPTR_W-1:0] bump(input logic [bdq_pkg::QPTR_W-1:0] p);
    bump = (p == bdq_pkg::QPTR_W'(bdq_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bdq_back.sv */
// bdq_back: chain of entry cells that executes one op per cycle and
// registers the result. Depends on bdq_pkg.
`default_nettype none

module bdq_back (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         op_valid,
  input  wire bdq_pkg::op_t op,
  output logic              done,
  output bdq_pkg::res_t     res
);

  logic signed [bdq_pkg::DATA_W-1:0] entries [bdq_pkg::DEPTH];
  logic [bdq_pkg::CNT_W-1:0]         count;
  logic [bdq_pkg::CNT_W-1:0]         count_next;

  logic [bdq_pkg::CMP_W-1:0] cnt_ext;
  logic [bdq_pkg::CMP_W-1:0] pos_ext;
  logic [bdq_pkg::CMP_W-1:0] eff_pos;
  logic [bdq_pkg::CMP_W-1:0] cnt_next_ext;
  logic [bdq_pkg::IDX_W-1:0] p_idx;
  logic                      do_ins;
  logic                      do_del;
  bdq_pkg::status_t          st;

  assign cnt_ext = bdq_pkg::CMP_W'(count);
  assign pos_ext = bdq_pkg::CMP_W'(op.position);

  // Resolve the target position and check bounds
  always_comb begin
    eff_pos = pos_ext;
    do_ins  = 1'b0;
    do_del  = 1'b0;
    st      = bdq_pkg::ST_OK;
    case (op.sel)
      bdq_pkg::SEL_FRONT: eff_pos = '0;
      bdq_pkg::SEL_REAR:  eff_pos = (op.kind == bdq_pkg::OP_DEL) ? cnt_ext - 1'b1 : cnt_ext;
      default:            eff_pos = pos_ext;
    endcase
    unique case (op.kind)
      bdq_pkg::OP_INS: begin
        if (op.sel == bdq_pkg::SEL_INDEX && pos_ext > cnt_ext) begin
          st = bdq_pkg::ST_RANGE;
        end else if (cnt_ext >= bdq_pkg::CMP_W'(bdq_pkg::DEPTH)) begin
          st = bdq_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      bdq_pkg::OP_DEL: begin
        if (count == '0) begin
          st = bdq_pkg::ST_EMPTY;
        end else if (op.sel == bdq_pkg::SEL_INDEX && pos_ext >= cnt_ext) begin
          st = bdq_pkg::ST_RANGE;
        end else begin
          do_del = 1'b1;
        end
      end
      default: begin
        st = bdq_pkg::ST_OK;
      end
    endcase
  end

  assign p_idx = eff_pos[bdq_pkg::IDX_W-1:0];

  always_comb begin
    count_next = count;
    if (op_valid && do_ins) begin
      count_next = count + 1'b1;
    end else if (op_valid && do_del) begin
      count_next = count - 1'b1;
    end
  end

  assign cnt_next_ext = bdq_pkg::CMP_W'(count_next);

  // Each cell takes its neighbor toward the front on insert, toward the rear on delete
  always_ff @(posedge clk) begin
    for (int i = 0; i < bdq_pkg::DEPTH; i++) begin
      if (op_valid && do_ins) begin
        if (bdq_pkg::IDX_W'(i) == p_idx) begin
          entries[i] <= op.value;
        end else if (bdq_pkg::IDX_W'(i) > p_idx) begin
          entries[i] <= entries[(i == 0) ? 0 : i - 1];
        end
      end else if (op_valid && do_del) begin
        if (bdq_pkg::IDX_W'(i) >= p_idx) begin
          entries[i] <= entries[(i == bdq_pkg::DEPTH - 1) ? i : i + 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    res.removed_value <= do_del ? entries[p_idx] : '0;
    res.status        <= st;
    res.entry_count   <= cnt_next_ext[bdq_pkg::ECNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= op_valid;
    end
  end

endmodule

`default_nettype wire
